>>> sv/spr_pkg.sv
// shared types and constants for the symmetric packed rank-1 update block
// used by spr_ctrl, spr_datapath and packed_symmetric_rank1_update
package spr_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int LEN_W     = 7;
    localparam int MAX_ORDER = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int Q_W       = 41;
    localparam int SUM_W     = 43;

    // configuration register indexes
    localparam logic [1:0] CFG_LOWER_PACKING = 2'd0;
    localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;
    localparam logic [1:0] CFG_SCALE_ALPHA   = 2'd2;

    // input function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

    // multiplier operand select
    localparam logic [1:0] MUL_AX = 2'd0;
    localparam logic [1:0] MUL_LO = 2'd1;
    localparam logic [1:0] MUL_HI = 2'd2;

    typedef struct packed {
        logic             take;
        logic             wr_vec;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             pass;
        logic             rd;
        logic             mul_en;
        logic [1:0]       mul_sel;
        logic             q_en;
        logic             out_en;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

>>> sv/spr_ctrl.sv
// controller: load count, packed position tracking and step sequencing
// depends on spr_pkg
module spr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_lower,
    input  logic [spr_pkg::LEN_W-1:0]  i_len,
    input  logic                       i_valid,
    input  logic                       i_func,
    output logic                       o_ready,
    input  spr_pkg::t_dp_status        i_status,
    output spr_pkg::t_dp_cmd           o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PASS = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_MUL3 = 3'd5;
    localparam logic [2:0] ST_QSUM = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]                r_state, n_state;
    logic [spr_pkg::LEN_W-1:0] r_load_cnt, n_load_cnt;
    logic [spr_pkg::IDX_W-1:0] r_row, n_row;
    logic [spr_pkg::IDX_W-1:0] r_col, n_col;

    logic [spr_pkg::LEN_W-1:0] ord;
    logic [spr_pkg::LEN_W-1:0] ord_m1;
    logic                      full;
    logic                      accept;
    logic                      pos_bad;
    logic [spr_pkg::IDX_W-1:0] eff_row, eff_col;
    logic                      is_last;

    always_comb begin
        if (i_len == '0) begin
            ord = spr_pkg::LEN_W'(1);
        end else if (i_len > spr_pkg::LEN_W'(spr_pkg::MAX_ORDER)) begin
            ord = spr_pkg::LEN_W'(spr_pkg::MAX_ORDER);
        end else begin
            ord = i_len;
        end
    end

    assign ord_m1  = ord - spr_pkg::LEN_W'(1);
    assign full    = (r_load_cnt >= ord);
    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    assign pos_bad = ({1'b0, r_col} >= ord) || ({1'b0, r_row} >= ord) ||
                     (i_lower ? (r_row < r_col) : (r_row > r_col));
    assign eff_row = pos_bad ? '0 : r_row;
    assign eff_col = pos_bad ? '0 : r_col;
    assign is_last = ({1'b0, eff_row} == ord_m1) && ({1'b0, eff_col} == ord_m1);

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_row      = r_row;
        n_col      = r_col;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == spr_pkg::FUNC_LOAD) begin
                        o_cmd.wr_vec = 1'b1;
                        if (full) begin
                            o_cmd.wr_addr = '0;
                            n_load_cnt    = spr_pkg::LEN_W'(1);
                            n_row         = '0;
                            n_col         = '0;
                        end else begin
                            o_cmd.wr_addr = r_load_cnt[spr_pkg::IDX_W-1:0];
                            n_load_cnt    = r_load_cnt + spr_pkg::LEN_W'(1);
                        end
                    end else if (!full) begin
                        o_cmd.take = 1'b1;
                        o_cmd.pass = 1'b1;
                        n_state    = ST_PASS;
                    end else begin
                        o_cmd.take = 1'b1;
                        o_cmd.row  = eff_row;
                        o_cmd.col  = eff_col;
                        o_cmd.last = is_last;
                        n_state    = ST_READ;
                        if (is_last) begin
                            n_row = '0;
                            n_col = '0;
                        end else if (i_lower) begin
                            if ({1'b0, eff_row} < ord_m1) begin
                                n_row = eff_row + spr_pkg::IDX_W'(1);
                                n_col = eff_col;
                            end else begin
                                n_col = eff_col + spr_pkg::IDX_W'(1);
                                n_row = eff_col + spr_pkg::IDX_W'(1);
                            end
                        end else begin
                            if (eff_row < eff_col) begin
                                n_row = eff_row + spr_pkg::IDX_W'(1);
                                n_col = eff_col;
                            end else begin
                                n_col = eff_col + spr_pkg::IDX_W'(1);
                                n_row = '0;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spr_pkg::MUL_AX;
                n_state       = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spr_pkg::MUL_LO;
                n_state       = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spr_pkg::MUL_HI;
                n_state       = ST_QSUM;
            end
            ST_QSUM: begin
                o_cmd.q_en = 1'b1;
                n_state    = ST_OUT;
            end
            ST_PASS, ST_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_en = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
        end
    end

endmodule

>>> sv/spr_datapath.sv
// datapath: vector store, shared multiplier, rounding, saturating add, output register
// depends on spr_pkg
module spr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [spr_pkg::DATA_W-1:0] i_alpha,
    input  logic        [spr_pkg::DATA_W-1:0] i_value,
    input  spr_pkg::t_dp_cmd                  i_cmd,
    output spr_pkg::t_dp_status               o_status,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [spr_pkg::OUT_TDATA_W-1:0]   o_data,
    output logic                              o_last,
    output logic                              o_stat
);

    localparam int DW = spr_pkg::DATA_W;

    logic [DW-1:0] mem [spr_pkg::MAX_ORDER];

    logic [DW-1:0]              r_val;
    logic [spr_pkg::IDX_W-1:0]  r_row, r_col;
    logic                       r_last, r_pass;
    logic [DW-1:0]              r_xr, r_xc;
    logic [spr_pkg::PROD_W-1:0] r_m1, r_plo, r_phi;
    logic [DW-1:0]              r_mr;
    logic                       r_neg;
    logic [spr_pkg::Q_W-1:0]    r_q;

    logic [DW-1:0]              r_out_val;
    logic [spr_pkg::IDX_W-1:0]  r_out_row, r_out_col;
    logic                       r_out_last, r_out_stat, r_out_vld;

    logic [DW-1:0]              amag, xcmag, xrmag;
    logic [DW-1:0]              op_a, op_b;
    logic [spr_pkg::PROD_W-1:0] prod;
    logic [spr_pkg::PROD_W-1:0] qsum;
    logic signed [spr_pkg::SUM_W-1:0] a_ext, q_ext, s;
    logic [DW-1:0]              sat;

    assign amag  = i_alpha[DW-1] ? (~i_alpha + DW'(1)) : i_alpha;
    assign xcmag = r_xc[DW-1] ? (~r_xc + DW'(1)) : r_xc;
    assign xrmag = r_xr[DW-1] ? (~r_xr + DW'(1)) : r_xr;

    always_comb begin
        case (i_cmd.mul_sel)
            spr_pkg::MUL_LO: begin
                op_a = r_m1[DW-1:0];
                op_b = r_mr;
            end
            spr_pkg::MUL_HI: begin
                op_a = r_m1[spr_pkg::PROD_W-1:DW];
                op_b = r_mr;
            end
            default: begin
                op_a = amag;
                op_b = xcmag;
            end
        endcase
    end

    assign prod = {{DW{1'b0}}, op_a} * {{DW{1'b0}}, op_b};

    // round to nearest, ties away, on the magnitude
    assign qsum = r_phi + ((r_plo + (spr_pkg::PROD_W'(1) << (DW - 1))) >> DW);

    assign a_ext = spr_pkg::SUM_W'(signed'(r_val));
    assign q_ext = signed'({2'b00, r_q});
    assign s     = r_neg ? (a_ext - q_ext) : (a_ext + q_ext);

    always_comb begin
        if (s > spr_pkg::SUM_W'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            sat = {1'b0, {(DW-1){1'b1}}};
        end else if (s < spr_pkg::SUM_W'(signed'({1'b1, {(DW-1){1'b0}}}))) begin
            sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat = s[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vec) begin
            mem[i_cmd.wr_addr] <= i_value;
        end
        if (i_cmd.rd) begin
            r_xr <= mem[r_row];
            r_xc <= mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_val  <= i_value;
            r_row  <= i_cmd.row;
            r_col  <= i_cmd.col;
            r_last <= i_cmd.last;
            r_pass <= i_cmd.pass;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                spr_pkg::MUL_LO: r_plo <= prod;
                spr_pkg::MUL_HI: r_phi <= prod;
                default: begin
                    r_m1  <= prod;
                    r_mr  <= xrmag;
                    r_neg <= i_alpha[DW-1] ^ r_xr[DW-1] ^ r_xc[DW-1];
                end
            endcase
        end
        if (i_cmd.q_en) begin
            if (qsum > (spr_pkg::PROD_W'(1) << (spr_pkg::Q_W - 1))) begin
                r_q <= spr_pkg::Q_W'(1) << (spr_pkg::Q_W - 1);
            end else begin
                r_q <= qsum[spr_pkg::Q_W-1:0];
            end
        end
        if (i_cmd.out_en) begin
            r_out_val  <= r_pass ? r_val : sat;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_last <= r_last;
            r_out_stat <= r_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_en) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_vld && !i_ready;
    assign o_valid = r_out_vld;
    assign o_data  = {{(spr_pkg::OUT_TDATA_W - DW - 2 * spr_pkg::IDX_W){1'b0}},
                      r_out_col, r_out_row, r_out_val};
    assign o_last  = r_out_last;
    assign o_stat  = r_out_stat;

endmodule

>>> sv/packed_symmetric_rank1_update.sv
// top level of the symmetric packed rank-1 update, configuration registers and assertions
// depends on spr_pkg, spr_ctrl and spr_datapath
//
// Computes a + alpha*x[row]*x[col] in signed Q16.16 with rounding and saturation for each
// word of a packed triangle streamed column by column. Vector words (tuser 0) are written
// into a 64-entry store. A matrix word (tuser 1) goes through these steps in order:
// accept, a two-port store read, three passes through one shared 32x32 multiplier, rounding,
// then the saturating add into the output register. A matrix word that arrives before the
// vector is complete passes through with status 1. The next word is accepted once the
// current one sits in the output register, even if that result is not yet taken.
module packed_symmetric_rank1_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] updated_value, [37:32] row_index, [43:38] col_index
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                              r_lower;
    logic [spr_pkg::LEN_W-1:0]         r_len;
    logic signed [spr_pkg::DATA_W-1:0] r_alpha;

    spr_pkg::t_dp_cmd    cmd;
    spr_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= 1'b0;
            r_len   <= spr_pkg::LEN_W'(spr_pkg::MAX_ORDER);
            r_alpha <= spr_pkg::DATA_W'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                spr_pkg::CFG_LOWER_PACKING: r_lower <= i_cfg_data[0];
                spr_pkg::CFG_VECTOR_LENGTH: r_len   <= i_cfg_data[spr_pkg::LEN_W-1:0];
                spr_pkg::CFG_SCALE_ALPHA:   r_alpha <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    spr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lower  (r_lower),
        .i_len    (r_len),
        .i_valid  (s_axis_tvalid),
        .i_func   (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    spr_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_alpha  (r_alpha),
        .i_value  (s_axis_tdata),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_stat   (m_axis_tuser)
    );

    // position stays on the configured side of the diagonal
    a_upper_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser && !r_lower) |-> (m_axis_tdata[37:32] <= m_axis_tdata[43:38]))
        else $error("upper packing result below diagonal");

    a_lower_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser && r_lower) |-> (m_axis_tdata[37:32] >= m_axis_tdata[43:38]))
        else $error("lower packing result above diagonal");

    // pass-through words carry no position
    a_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[43:32] == '0 && !m_axis_tlast))
        else $error("pass-through word carries position");

    // an accepted matrix word stalls the input: s_axis_tready drops once it is taken
    a_matrix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == spr_pkg::FUNC_MATRIX) |=> !s_axis_tready)
        else $error("matrix word did not stall input");

endmodule
